/* rtl/core/priority_thread_scheduler_assert.svh */
// Assertion macros for the thread scheduler RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef PRIORITY_THREAD_SCHEDULER_ASSERT_SVH
`define PRIORITY_THREAD_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define PTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication.
`define PTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

/* rtl/core/pts_pkg.sv */
// Shared codes and enums of the thread scheduler.
// No dependencies.
package pts_pkg;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned PRIO_W = 4;
  localparam int unsigned TID_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 3'd0,
    REQ_YIELD  = 3'd1,
    REQ_EXIT   = 3'd2,
    REQ_JOIN   = 3'd3,
    REQ_DETACH = 3'd4
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_NO_SLOT  = 3'd2,
    ST_DEADLOCK = 3'd3,
    ST_NO_READY = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    TS_UNUSED   = 3'd0,
    TS_READY    = 3'd1,
    TS_RUNNING  = 3'd2,
    TS_BLOCKED  = 3'd3,
    TS_FINISHED = 3'd4
  } slot_state_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_SWP_RD, S_SWP_CK, S_SWP_END, S_Y_CK,
    S_POP, S_POP_WT, S_J_BLK, S_RUN_RD, S_RUN, S_X_CK, S_X_J, S_J_CK,
    S_D_CK, S_DONE
  } fsm_e;

endpackage

/* rtl/core/pts_if.sv */
// Request and response channel interfaces of the thread scheduler.
// Depends on pts_pkg.
interface pts_req_if import pts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [PRIO_W-1:0] new_priority;
  logic [TID_W-1:0]  target_thread;
  logic [VAL_W-1:0]  exit_value;
  modport source (output valid, req_type, new_priority, target_thread, exit_value,
                  input ready);
  modport sink (input valid, req_type, new_priority, target_thread, exit_value,
                output ready);
endinterface

interface pts_rsp_if import pts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TID_W-1:0]  running_thread;
  logic              switched;
  logic [TID_W-1:0]  created_thread;
  logic [VAL_W-1:0]  joined_value;
  modport source (output valid, status, running_thread, switched, created_thread,
                  joined_value, input ready);
  modport sink (input valid, status, running_thread, switched, created_thread,
                joined_value, output ready);
endinterface

/* rtl/core/priority_thread_scheduler.sv */
// Fixed-priority FIFO thread scheduler: one request in, one result out per
// transfer. The thread table lives in a single-port-read synchronous memory and
// the ready rings in a second one, so every request runs as a short sequence of
// read/modify/write steps. After reset the table is cleared slot by slot, and
// no request is taken until that is done. Create, yield and a detach of a
// valid thread sweep the whole table to free finished detached threads,
// reading and then checking each slot in turn. A new request is taken only once
// the result of the last one is loaded into the output register, where it
// waits while the next request is taken. Depends on pts_pkg, pts_if and the
// assert header.
`include "priority_thread_scheduler_assert.svh"

module priority_thread_scheduler import pts_pkg::*; #(
  parameter int unsigned THREAD_SLOTS    = 128,
  parameter int unsigned PRIORITY_LEVELS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pts_req_if.sink   req_i,
  pts_rsp_if.source rsp_o
);

  localparam int unsigned IDW   = $clog2(THREAD_SLOTS);
  localparam int unsigned LW    = $clog2(PRIORITY_LEVELS);
  localparam int unsigned CNTW  = $clog2(THREAD_SLOTS + 1);
  localparam int unsigned TOTW  = $clog2(PRIORITY_LEVELS * THREAD_SLOTS + 1);
  localparam int unsigned RDEP  = PRIORITY_LEVELS * (2 ** IDW);
  localparam logic [IDW-1:0] LAST = IDW'(THREAD_SLOTS - 1);

  typedef struct packed {
    slot_state_e       st;
    logic [PRIO_W-1:0] prio;
    logic              det;
    logic              hasj;
    logic [IDW-1:0]    joiner;
    logic [VAL_W-1:0]  result;
  } slot_t;

  localparam slot_t SLOT_FREE = '{st: TS_UNUSED, prio: '0, det: 1'b0, hasj: 1'b0,
                                  joiner: '0, result: '0};

  function automatic logic [LW-1:0] lvl_of(logic [PRIO_W-1:0] p);
    return (32'(p) >= PRIORITY_LEVELS) ? LW'(PRIORITY_LEVELS - 1) : LW'(p);
  endfunction

  fsm_e state_q, state_d;
  logic [IDW-1:0] cnt_q, cnt_d, first_q, first_d, cur_q, cur_d;
  logic [IDW-1:0] next_q, next_d, joiner_q, joiner_d, created_q, created_d;
  logic found_q, found_d;
  status_e status_q, status_d;
  logic [VAL_W-1:0] jval_q, jval_d;

  logic [REQ_W-1:0]  req_q;
  logic [PRIO_W-1:0] prio_q;
  logic [TID_W-1:0]  tgt_q;
  logic [VAL_W-1:0]  xval_q;
  logic [IDW-1:0]    prev_q;

  logic              ov_q;
  logic [STAT_W-1:0] o_status_q;
  logic [TID_W-1:0]  o_run_q, o_created_q;
  logic              o_sw_q;
  logic [VAL_W-1:0]  o_jval_q;

  slot_t          slot_mem [THREAD_SLOTS];
  slot_t          slot_rd_q, slot_wdata;
  logic           slot_re, slot_we;
  logic [IDW-1:0] slot_raddr, slot_waddr;

  logic [IDW-1:0]  ring_mem [RDEP];
  logic [IDW-1:0]  ring_rd_q;
  logic [IDW-1:0]  head_q [PRIORITY_LEVELS];
  logic [IDW-1:0]  tail_q [PRIORITY_LEVELS];
  logic [CNTW-1:0] count_q [PRIORITY_LEVELS];
  logic [TOTW-1:0] total_q;

  logic           push_en, pop_en, push_ok;
  logic [IDW-1:0] push_id;
  logic [LW-1:0]  push_lvl, pop_lvl;

  logic           accept, tgt_bad, done_go;
  logic [IDW-1:0] tgt_id;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign tgt_id      = IDW'(tgt_q);
  assign tgt_bad     = (tgt_q == '0) || (32'(tgt_q) >= THREAD_SLOTS);
  assign done_go     = (state_q == S_DONE) && (!ov_q || rsp_o.ready);
  assign push_ok     = push_en && (32'(count_q[push_lvl]) < THREAD_SLOTS);

  // Highest non-empty level.
  always_comb begin
    pop_lvl = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (count_q[i] != '0) pop_lvl = LW'(i);
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    first_d   = first_q;
    found_d   = found_q;
    cur_d     = cur_q;
    next_d    = next_q;
    joiner_d  = joiner_q;
    created_d = created_q;
    status_d  = status_q;
    jval_d    = jval_q;
    slot_re    = 1'b0;
    slot_raddr = '0;
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = slot_rd_q;
    push_en  = 1'b0;
    push_id  = '0;
    push_lvl = '0;
    pop_en   = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = cnt_q;
        slot_wdata = SLOT_FREE;
        if (cnt_q == '0) slot_wdata.st = TS_RUNNING;
        if (cnt_q == LAST) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) state_d = S_DISP;
      end
      S_DISP: begin
        status_d  = ST_OK;
        created_d = '0;
        jval_d    = '0;
        found_d   = 1'b0;
        cnt_d     = IDW'(1);
        case (req_q)
          REQ_CREATE, REQ_YIELD: state_d = S_SWP_RD;
          REQ_EXIT: begin
            slot_re    = 1'b1;
            slot_raddr = prev_q;
            state_d    = S_X_CK;
          end
          REQ_JOIN: begin
            if (tgt_bad || tgt_id == prev_q) begin
              status_d = ST_INVALID;
              state_d  = S_DONE;
            end else begin
              slot_re    = 1'b1;
              slot_raddr = tgt_id;
              state_d    = S_J_CK;
            end
          end
          REQ_DETACH: begin
            if (tgt_bad) begin
              status_d = ST_INVALID;
              state_d  = S_DONE;
            end else begin
              slot_re    = 1'b1;
              slot_raddr = tgt_id;
              state_d    = S_D_CK;
            end
          end
          default: begin
            status_d = ST_INVALID;
            state_d  = S_DONE;
          end
        endcase
      end
      S_SWP_RD: begin
        slot_re    = 1'b1;
        slot_raddr = cnt_q;
        state_d    = S_SWP_CK;
      end
      S_SWP_CK: begin
        // Free finished detached threads and note the lowest free slot.
        if (slot_rd_q.st == TS_FINISHED && slot_rd_q.det) begin
          slot_we    = 1'b1;
          slot_waddr = cnt_q;
          slot_wdata = SLOT_FREE;
        end
        if (!found_q && (slot_rd_q.st == TS_UNUSED ||
                         (slot_rd_q.st == TS_FINISHED && slot_rd_q.det))) begin
          found_d = 1'b1;
          first_d = cnt_q;
        end
        if (cnt_q == LAST) begin
          state_d = S_SWP_END;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_SWP_RD;
        end
      end
      S_SWP_END: begin
        state_d = S_DONE;
        case (req_q)
          REQ_CREATE: begin
            if (32'(prio_q) >= PRIORITY_LEVELS) begin
              status_d = ST_INVALID;
            end else if (!found_q) begin
              status_d = ST_NO_SLOT;
            end else begin
              slot_we         = 1'b1;
              slot_waddr      = first_q;
              slot_wdata      = SLOT_FREE;
              slot_wdata.st   = TS_READY;
              slot_wdata.prio = prio_q;
              push_en   = 1'b1;
              push_id   = first_q;
              push_lvl  = lvl_of(prio_q);
              created_d = first_q;
            end
          end
          REQ_YIELD: begin
            if (total_q != '0) begin
              slot_re    = 1'b1;
              slot_raddr = prev_q;
              state_d    = S_Y_CK;
            end
          end
          default: ;
        endcase
      end
      S_Y_CK: begin
        if (slot_rd_q.st == TS_RUNNING) begin
          slot_we       = 1'b1;
          slot_waddr    = prev_q;
          slot_wdata.st = TS_READY;
          push_en  = 1'b1;
          push_id  = prev_q;
          push_lvl = lvl_of(slot_rd_q.prio);
        end
        state_d = S_POP;
      end
      S_POP: begin
        if (total_q == '0) begin
          if (req_q == REQ_EXIT) status_d = ST_NO_READY;
          if (req_q == REQ_JOIN) status_d = ST_DEADLOCK;
          state_d = S_DONE;
        end else begin
          pop_en  = 1'b1;
          state_d = S_POP_WT;
        end
      end
      S_POP_WT: begin
        next_d  = ring_rd_q;
        slot_re = 1'b1;
        if (req_q == REQ_JOIN) begin
          slot_raddr = prev_q;
          state_d    = S_J_BLK;
        end else begin
          slot_raddr = ring_rd_q;
          state_d    = S_RUN;
        end
      end
      S_J_BLK: begin
        slot_we       = 1'b1;
        slot_waddr    = prev_q;
        slot_wdata.st = TS_BLOCKED;
        state_d       = S_RUN_RD;
      end
      S_RUN_RD: begin
        slot_re    = 1'b1;
        slot_raddr = next_q;
        state_d    = S_RUN;
      end
      S_RUN: begin
        slot_we       = 1'b1;
        slot_waddr    = next_q;
        slot_wdata.st = TS_RUNNING;
        cur_d         = next_q;
        state_d       = S_DONE;
      end
      S_X_CK: begin
        slot_we           = 1'b1;
        slot_waddr        = prev_q;
        slot_wdata.st     = TS_FINISHED;
        slot_wdata.result = xval_q;
        if (slot_rd_q.hasj) begin
          joiner_d   = slot_rd_q.joiner;
          slot_re    = 1'b1;
          slot_raddr = slot_rd_q.joiner;
          state_d    = S_X_J;
        end else begin
          state_d = S_POP;
        end
      end
      S_X_J: begin
        // Wake the blocked joiner.
        if (slot_rd_q.st == TS_BLOCKED) begin
          slot_we       = 1'b1;
          slot_waddr    = joiner_q;
          slot_wdata.st = TS_READY;
          push_en  = 1'b1;
          push_id  = joiner_q;
          push_lvl = lvl_of(slot_rd_q.prio);
        end
        state_d = S_POP;
      end
      S_J_CK: begin
        if (slot_rd_q.st == TS_UNUSED || slot_rd_q.det ||
            (slot_rd_q.hasj && slot_rd_q.joiner != prev_q)) begin
          status_d = ST_INVALID;
          state_d  = S_DONE;
        end else if (slot_rd_q.st == TS_FINISHED) begin
          jval_d     = slot_rd_q.result;
          slot_we    = 1'b1;
          slot_waddr = tgt_id;
          slot_wdata = SLOT_FREE;
          state_d    = S_DONE;
        end else begin
          slot_we           = 1'b1;
          slot_waddr        = tgt_id;
          slot_wdata.hasj   = 1'b1;
          slot_wdata.joiner = prev_q;
          state_d           = S_POP;
        end
      end
      S_D_CK: begin
        if (slot_rd_q.st == TS_UNUSED) begin
          status_d = ST_INVALID;
          state_d  = S_DONE;
        end else begin
          slot_we        = 1'b1;
          slot_waddr     = tgt_id;
          slot_wdata.det = 1'b1;
          state_d        = S_SWP_RD;
        end
      end
      S_DONE: begin
        if (done_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      first_q   <= '0;
      found_q   <= 1'b0;
      cur_q     <= '0;
      next_q    <= '0;
      joiner_q  <= '0;
      created_q <= '0;
      status_q  <= ST_OK;
      jval_q    <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      first_q   <= first_d;
      found_q   <= found_d;
      cur_q     <= cur_d;
      next_q    <= next_d;
      joiner_q  <= joiner_d;
      created_q <= created_d;
      status_q  <= status_d;
      jval_q    <= jval_d;
      if (done_go) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_i.req_type;
      prio_q <= req_i.new_priority;
      tgt_q  <= req_i.target_thread;
      xval_q <= req_i.exit_value;
      prev_q <= cur_q;
    end
    if (done_go) begin
      o_status_q  <= status_q;
      o_run_q     <= TID_W'(cur_q);
      o_sw_q      <= (cur_q != prev_q);
      o_created_q <= TID_W'(created_q);
      o_jval_q    <= jval_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rd_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) ring_mem[{push_lvl, tail_q[push_lvl]}] <= push_id;
    if (pop_en)  ring_rd_q <= ring_mem[{pop_lvl, head_q[pop_lvl]}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
      total_q <= '0;
    end else begin
      if (push_ok) begin
        tail_q[push_lvl]  <= (tail_q[push_lvl] == LAST) ? '0 : tail_q[push_lvl] + 1'b1;
        count_q[push_lvl] <= count_q[push_lvl] + 1'b1;
        total_q           <= total_q + 1'b1;
      end else if (pop_en) begin
        head_q[pop_lvl]  <= (head_q[pop_lvl] == LAST) ? '0 : head_q[pop_lvl] + 1'b1;
        count_q[pop_lvl] <= count_q[pop_lvl] - 1'b1;
        total_q          <= total_q - 1'b1;
      end
    end
  end

  assign rsp_o.valid          = ov_q;
  assign rsp_o.status         = o_status_q;
  assign rsp_o.running_thread = o_run_q;
  assign rsp_o.switched       = o_sw_q;
  assign rsp_o.created_thread = o_created_q;
  assign rsp_o.joined_value   = o_jval_q;

  `PTS_ASSERT_IMP(a_pop_nonempty, pop_en, (total_q != '0) && !push_en)
  `PTS_ASSERT_IMP(a_slot_no_rw_clash, slot_we && slot_re, slot_waddr != slot_raddr)
  `PTS_ASSERT_NXT(a_rsp_from_done, done_go, rsp_o.valid && (state_q == S_IDLE))
  `PTS_ASSERT_IMP(a_run_sets_current, state_q == S_RUN, slot_wdata.st == TS_RUNNING)

endmodule
